// ===== rtl/core/gpc_pkg.sv =====
// Package for the grid path counter: sequencer step, operation and condition types,
// the control word layout and the read-only microprogram table.
// No dependencies.
`timescale 1ns / 1ps

package gpc_pkg;

    // Saturation value of the 32-bit path count.
    localparam logic [31:0] SAT_VALUE = 32'hFFFF_FFFF;

    // Sequencer steps, one per control word.
    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_CHECK  = 3'd1,
        S_INIT   = 3'd2,
        S_ROW    = 3'd3,
        S_CELL   = 3'd4,
        S_ROWEND = 3'd5,
        S_DONE   = 3'd6,
        S_ZERO   = 3'd7
    } step_t;

    // Datapath operation selected by a control word.
    typedef enum logic [2:0] {
        OP_ACCEPT = 3'd0,
        OP_NOP    = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_ROW    = 3'd3,
        OP_CELL   = 3'd4,
        OP_ROWINC = 3'd5,
        OP_RESULT = 3'd6,
        OP_ZERO   = 3'd7
    } op_t;

    // Branch condition tested at the end of a step.
    typedef enum logic [2:0] {
        C_IN_TAKEN = 3'd0,
        C_DIM_ZERO = 3'd1,
        C_COL_LAST = 3'd2,
        C_NC_ONE   = 3'd3,
        C_ROW_LAST = 3'd4,
        C_OUT_FREE = 3'd5
    } cond_t;

    // One control word: operation, condition and the two branch targets.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jmp_true;
        step_t jmp_false;
    } ucode_t;

    // Microprogram table.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t word;
        case (step)
            S_IDLE:   word = '{OP_ACCEPT, C_IN_TAKEN, S_CHECK,  S_IDLE};
            S_CHECK:  word = '{OP_NOP,    C_DIM_ZERO, S_ZERO,   S_INIT};
            S_INIT:   word = '{OP_CLEAR,  C_COL_LAST, S_ROW,    S_INIT};
            S_ROW:    word = '{OP_ROW,    C_NC_ONE,   S_ROWEND, S_CELL};
            S_CELL:   word = '{OP_CELL,   C_COL_LAST, S_ROWEND, S_CELL};
            S_ROWEND: word = '{OP_ROWINC, C_ROW_LAST, S_DONE,   S_ROW};
            S_DONE:   word = '{OP_RESULT, C_OUT_FREE, S_IDLE,   S_DONE};
            S_ZERO:   word = '{OP_ZERO,   C_OUT_FREE, S_IDLE,   S_ZERO};
            default:  word = '{OP_ACCEPT, C_IN_TAKEN, S_CHECK,  S_IDLE};
        endcase
        return word;
    endfunction

endpackage

// ===== rtl/core/grid_path_counter_top.sv =====
// Top level of the grid path counter: microcoded sequencer, row store and output register.
// Depends on gpc_pkg and gpc_ram.
`timescale 1ns / 1ps

// Counts the monotone right/down paths across a grid of rows by cols cells, that is
// C(rows+cols-2, rows-1), with sums that saturate at all ones and raise the overflow
// flag. Dimensions above MAX_DIM are clamped to MAX_DIM; a zero dimension returns a
// count of zero. One transaction is handled at a time, and its duration is set by the
// row store, which is read and written once per grid cell outside the first column,
// with one saturating add per such cell. A finished result waits in the output
// register while the next transaction is accepted.
module grid_path_counter_top
    import gpc_pkg::*;
#(
    parameter int MAX_DIM = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rows [7:0], cols [15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // path_count [31:0]
    output logic        m_tuser    // overflow [0]
);

    localparam int AW    = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CW    = (DIM_W > 8) ? DIM_W : 8;

    step_t            step_reg, step_next;
    ucode_t           ctrl;
    logic [DIM_W-1:0] nr_reg, nr_next;
    logic [DIM_W-1:0] nc_reg, nc_next;
    logic [AW-1:0]    row_reg, row_next;
    logic [AW-1:0]    col_reg, col_next;
    logic [31:0]      left_reg, left_next;
    logic             ovf_reg, ovf_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_count_reg, out_count_next;
    logic             out_ovf_reg, out_ovf_next;

    logic [DIM_W-1:0] rows_clamped, cols_clamped;
    logic             in_taken, out_free, cond_true;
    logic [32:0]      cell_sum;
    logic [31:0]      cell_value;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [31:0]      ram_wdata, ram_rdata;

    // Row store.
    gpc_ram #(
        .WIDTH(32),
        .DEPTH(MAX_DIM)
    ) u_row_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Clamp the incoming dimensions to the store depth.
    always_comb begin
        if (CW'(s_tdata[7:0]) > CW'(MAX_DIM)) begin
            rows_clamped = DIM_W'(MAX_DIM);
        end else begin
            rows_clamped = DIM_W'(s_tdata[7:0]);
        end
        if (CW'(s_tdata[15:8]) > CW'(MAX_DIM)) begin
            cols_clamped = DIM_W'(MAX_DIM);
        end else begin
            cols_clamped = DIM_W'(s_tdata[15:8]);
        end
    end

    // Saturating add of the stored entry and its left neighbor.
    always_comb begin
        cell_sum = {1'b0, ram_rdata} + {1'b0, left_reg};
        if (cell_sum[32]) begin
            cell_value = SAT_VALUE;
        end else begin
            cell_value = cell_sum[31:0];
        end
    end

    assign ctrl     = ucode_rom(step_reg);
    assign s_tready = (ctrl.op == OP_ACCEPT);
    assign in_taken = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Branch condition selected by the control word.
    always_comb begin
        case (ctrl.cond)
            C_IN_TAKEN: cond_true = in_taken;
            C_DIM_ZERO: cond_true = (nr_reg == '0) || (nc_reg == '0);
            C_COL_LAST: cond_true = DIM_W'(col_reg) >= (nc_reg - DIM_W'(1));
            C_NC_ONE:   cond_true = (nc_reg == DIM_W'(1));
            C_ROW_LAST: cond_true = DIM_W'(row_reg) == (nr_reg - DIM_W'(1));
            C_OUT_FREE: cond_true = out_free;
            default:    cond_true = 1'b0;
        endcase
    end

    // Step counter and datapath driven by the current control word.
    always_comb begin
        step_next      = cond_true ? ctrl.jmp_true : ctrl.jmp_false;
        nr_next        = nr_reg;
        nc_next        = nc_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        left_next      = left_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;
        ram_we         = 1'b0;
        ram_waddr      = col_reg;
        ram_wdata      = '0;
        ram_raddr      = AW'(col_reg + AW'(1));
        case (ctrl.op)
            OP_ACCEPT: begin
                if (in_taken) begin
                    nr_next  = rows_clamped;
                    nc_next  = cols_clamped;
                    row_next = '0;
                    col_next = AW'(1);
                    ovf_next = 1'b0;
                end
            end
            OP_NOP: begin
            end
            OP_CLEAR: begin
                ram_we   = 1'b1;
                col_next = AW'(col_reg + AW'(1));
            end
            OP_ROW: begin
                // Entry zero is always one, so the row starts from it directly.
                left_next = 32'd1;
                col_next  = AW'(1);
                ram_raddr = AW'(1);
            end
            OP_CELL: begin
                ram_we    = 1'b1;
                ram_wdata = cell_value;
                left_next = cell_value;
                col_next  = AW'(col_reg + AW'(1));
                if (cell_sum[32]) begin
                    ovf_next = 1'b1;
                end
            end
            OP_ROWINC: begin
                row_next = AW'(row_reg + AW'(1));
            end
            OP_RESULT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_count_next = left_reg;
                    out_ovf_next   = ovf_reg;
                end
            end
            OP_ZERO: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_count_next = '0;
                    out_ovf_next   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= S_IDLE;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            left_reg      <= '0;
            ovf_reg       <= 1'b0;
        end else begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            left_reg      <= left_next;
            ovf_reg       <= ovf_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        nr_reg        <= nr_next;
        nc_reg        <= nc_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_count_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

// ===== rtl/core/gpc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module gpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read share the clock.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/gpc_checker.sv =====
// Port-level checker for the grid path counter and its bind to the top level.
// Depends on grid_path_counter_top.
`timescale 1ns / 1ps

module gpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
    else $error("result pending after reset");

    // Once a transaction is taken, the sequencer is busy on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while computing");

    // Saturation anywhere leaves the final count saturated.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 32'hFFFF_FFFF)
    else $error("overflow flagged on an unsaturated count");

endmodule

bind grid_path_counter_top gpc_checker u_gpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
